// ===== rtl/cnds_pkg.sv =====
// ============================================================================
// cnds_pkg
// Shared widths, register indexes, reset values and setup states for the
// crop and nearest-neighbor downscale block.
// ============================================================================
package cnds_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIXEL_W      = 32;
  localparam int SIZE_CFG_W   = 13;
  localparam int ORIGIN_CFG_W = 12;
  localparam int SCALE_CFG_W  = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 3;

  // Scale factor is a fraction with this many bits below the point
  localparam int SCALE_FRAC = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_FRAME_WIDTH  = 3'd0;
  localparam cfg_idx_t CFG_FRAME_HEIGHT = 3'd1;
  localparam cfg_idx_t CFG_CROP_LEFT    = 3'd2;
  localparam cfg_idx_t CFG_CROP_TOP     = 3'd3;
  localparam cfg_idx_t CFG_CROP_COLS    = 3'd4;
  localparam cfg_idx_t CFG_CROP_ROWS    = 3'd5;
  localparam cfg_idx_t CFG_SCALE_FACTOR = 3'd6;

  localparam logic [SIZE_CFG_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [SIZE_CFG_W-1:0] RST_FRAME_HEIGHT = 13'd1080;

  typedef enum logic [2:0] {
    ST_GEOM,
    ST_CLIP,
    ST_SCALE,
    ST_DIV,
    ST_START,
    ST_RUN
  } setup_state_t;

endpackage

// ===== rtl/crop_and_nearest_downscale.sv =====
// ============================================================================
// crop_and_nearest_downscale
// Crop window plus nearest-neighbor downscale on a raster pixel stream.
// ============================================================================
// Source pixels enter one beat per clock in raster order and only the kept
// ones leave, unchanged, with out_tlast marking the end of an output row and
// out_tuser[0] the end of the output frame. Once running, the block takes one
// input beat every cycle unless its skid stage holds a beat; a compare of
// the source position against the next wanted row and column plus one
// accumulator add decide each pixel. After reset and after every
// configuration write the block recomputes its window geometry and holds
// in_tready low through the GEOM, CLIP, SCALE, DIV and START states; the
// bit-serial dividers in the DIV state find the column and row step
// sizes. The stream restarts at a new frame after each write and after
// the last pixel of every source frame.
module crop_and_nearest_downscale #(
  parameter int MAX_WIDTH  = cnds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cnds_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cnds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cnds_pkg::CFG_DATA_W-1:0] cfg_data,
  // source pixels
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cnds_pkg::PIXEL_W-1:0]   in_tdata,   // [31:0] src_pixel
  // kept pixels
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cnds_pkg::PIXEL_W-1:0]   out_tdata,  // [31:0] out_pixel
  output logic                           out_tlast,  // row_end
  output logic                           out_tuser   // [0] frame_end
);

  import cnds_pkg::*;

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int XWW  = (WW > SIZE_CFG_W) ? WW : SIZE_CFG_W;
  localparam int XHW  = (HW > SIZE_CFG_W) ? HW : SIZE_CFG_W;
  localparam int DW   = (WW > HW) ? WW : HW;
  localparam int CNW  = $clog2(DW);
  localparam int PWW  = WW + SCALE_CFG_W;
  localparam int PHW  = HW + SCALE_CFG_W;
  localparam int ROUND_HALF = 1 << (SCALE_FRAC - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SIZE_CFG_W-1:0]   frame_width_r, frame_height_r;
  logic [ORIGIN_CFG_W-1:0] crop_left_r, crop_top_r;
  logic [SIZE_CFG_W-1:0]   crop_cols_r, crop_rows_r;
  logic [SCALE_CFG_W-1:0]  scale_factor_r;
  logic                    cfg_write;

  assign cfg_ready = 1'b1;

  always_comb begin
    case (cfg_index)
      CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_CROP_LEFT, CFG_CROP_TOP,
      CFG_CROP_COLS, CFG_CROP_ROWS, CFG_SCALE_FACTOR: begin
        cfg_write = cfg_valid;
      end
      default: begin
        cfg_write = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      crop_left_r    <= '0;
      crop_top_r     <= '0;
      crop_cols_r    <= '0;
      crop_rows_r    <= '0;
      scale_factor_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[SIZE_CFG_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[SIZE_CFG_W-1:0];
        CFG_CROP_LEFT:    crop_left_r    <= cfg_data[ORIGIN_CFG_W-1:0];
        CFG_CROP_TOP:     crop_top_r     <= cfg_data[ORIGIN_CFG_W-1:0];
        CFG_CROP_COLS:    crop_cols_r    <= cfg_data[SIZE_CFG_W-1:0];
        CFG_CROP_ROWS:    crop_rows_r    <= cfg_data[SIZE_CFG_W-1:0];
        CFG_SCALE_FACTOR: scale_factor_r <= cfg_data[SCALE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Setup sequencer
  // --------------------------------------------------------------------------
  setup_state_t state_r, state_nxt;
  logic [CNW-1:0] div_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_GEOM;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_GEOM:  state_nxt = ST_CLIP;
      ST_CLIP:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_cnt_r == CNW'(DW - 1)) begin
          state_nxt = ST_START;
        end
      end
      ST_START: state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_GEOM;
    endcase
    // any register write restarts the geometry
    if (cfg_write) begin
      state_nxt = ST_GEOM;
    end
  end

  // --------------------------------------------------------------------------
  // Geometry datapath
  // --------------------------------------------------------------------------
  logic [WW-1:0] fw_r, x0_r, wc_r, nw_r, col_start_r, cq_r, cr_r;
  logic [HW-1:0] fh_r, y0_r, hc_r, nh_r, row_start_r, rq_r, rr_r;
  logic [WW:0]   col_err0_r, col_step2_r, nw2_r;
  logic [HW:0]   row_err0_r, row_step2_r, nh2_r;

  logic [XWW-1:0] fw_x, cl_x, cc_x, fw_lim;
  logic [XHW-1:0] fh_x, ct_x, cr_x, fh_lim;
  logic [WW-1:0]  fw_calc, x0_calc, wc_calc, w_rest, nw_calc;
  logic [HW-1:0]  fh_calc, y0_calc, hc_calc, h_rest, nh_calc;
  logic [PWW-1:0] prod_w;
  logic [PHW-1:0] prod_h;
  logic           crop_en;

  always_comb begin
    // saturate the frame size into 1..MAX
    fw_x = XWW'(frame_width_r);
    fh_x = XHW'(frame_height_r);
    if (fw_x == '0) begin
      fw_calc = WW'(1);
    end else if (fw_x > XWW'(MAX_WIDTH)) begin
      fw_calc = WW'(MAX_WIDTH);
    end else begin
      fw_calc = fw_x[WW-1:0];
    end
    if (fh_x == '0) begin
      fh_calc = HW'(1);
    end else if (fh_x > XHW'(MAX_HEIGHT)) begin
      fh_calc = HW'(MAX_HEIGHT);
    end else begin
      fh_calc = fh_x[HW-1:0];
    end

    // clamp crop origin into the frame, size into the rest of it; a zero crop size keeps the whole frame
    crop_en = (crop_cols_r != '0) && (crop_rows_r != '0);
    cl_x    = XWW'(crop_left_r);
    ct_x    = XHW'(crop_top_r);
    cc_x    = XWW'(crop_cols_r);
    cr_x    = XHW'(crop_rows_r);
    fw_lim  = XWW'(fw_r) - XWW'(1);
    fh_lim  = XHW'(fh_r) - XHW'(1);
    x0_calc = (cl_x > fw_lim) ? fw_lim[WW-1:0] : cl_x[WW-1:0];
    y0_calc = (ct_x > fh_lim) ? fh_lim[HW-1:0] : ct_x[HW-1:0];
    w_rest  = fw_r - x0_calc;
    h_rest  = fh_r - y0_calc;
    wc_calc = (cc_x > XWW'(w_rest)) ? w_rest : cc_x[WW-1:0];
    hc_calc = (cr_x > XHW'(h_rest)) ? h_rest : cr_x[HW-1:0];
    if (!crop_en) begin
      x0_calc = '0;
      y0_calc = '0;
      wc_calc = fw_r;
      hc_calc = fh_r;
    end

    // output size: round(size * factor), at least one; a zero factor keeps the crop size
    prod_w  = PWW'(wc_r) * PWW'(scale_factor_r) + PWW'(ROUND_HALF);
    prod_h  = PHW'(hc_r) * PHW'(scale_factor_r) + PHW'(ROUND_HALF);
    nw_calc = prod_w[PWW-1:SCALE_FRAC];
    nh_calc = prod_h[PHW-1:SCALE_FRAC];
    if (nw_calc == '0) begin
      nw_calc = WW'(1);
    end
    if (nh_calc == '0) begin
      nh_calc = HW'(1);
    end
    if (scale_factor_r == '0) begin
      nw_calc = wc_r;
      nh_calc = hc_r;
    end
  end

  // Restoring dividers: size / n, one quotient bit per cycle, both axes
  logic [WW:0]   col_rsh;
  logic [HW:0]   row_rsh;
  logic          col_ge, row_ge, col_div_on, row_div_on;

  always_comb begin
    col_rsh    = {cr_r, cq_r[WW-1]};
    row_rsh    = {rr_r, rq_r[HW-1]};
    col_ge     = col_rsh >= {1'b0, nw_r};
    row_ge     = row_rsh >= {1'b0, nh_r};
    col_div_on = {1'b0, div_cnt_r} < (CNW+1)'(WW);
    row_div_on = {1'b0, div_cnt_r} < (CNW+1)'(HW);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_GEOM: begin
        fw_r <= fw_calc;
        fh_r <= fh_calc;
      end
      ST_CLIP: begin
        x0_r <= x0_calc;
        y0_r <= y0_calc;
        wc_r <= wc_calc;
        hc_r <= hc_calc;
      end
      ST_SCALE: begin
        nw_r      <= nw_calc;
        nh_r      <= nh_calc;
        cq_r      <= wc_r;
        rq_r      <= hc_r;
        cr_r      <= '0;
        rr_r      <= '0;
        div_cnt_r <= '0;
      end
      ST_DIV: begin
        div_cnt_r <= div_cnt_r + CNW'(1);
        if (col_div_on) begin
          cr_r <= col_ge ? WW'(col_rsh - {1'b0, nw_r}) : col_rsh[WW-1:0];
          cq_r <= {cq_r[WW-2:0], col_ge};
        end
        if (row_div_on) begin
          rr_r <= row_ge ? HW'(row_rsh - {1'b0, nh_r}) : row_rsh[HW-1:0];
          rq_r <= {rq_r[HW-2:0], row_ge};
        end
      end
      ST_START: begin
        // first pick: base + size/(2n), remainder size mod 2n
        col_start_r <= x0_r + (cq_r >> 1);
        row_start_r <= y0_r + (rq_r >> 1);
        col_err0_r  <= (cq_r[0] ? {1'b0, nw_r} : '0) + {1'b0, cr_r};
        row_err0_r  <= (rq_r[0] ? {1'b0, nh_r} : '0) + {1'b0, rr_r};
        col_step2_r <= {cr_r, 1'b0};
        row_step2_r <= {rr_r, 1'b0};
        nw2_r       <= {nw_r, 1'b0};
        nh2_r       <= {nh_r, 1'b0};
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Per-pixel selection
  // --------------------------------------------------------------------------
  logic [WW-1:0] in_col_r, out_col_r, wanted_col_r;
  logic [HW-1:0] in_row_r, out_row_r, wanted_row_r;
  logic [WW:0]   col_err_r;
  logic [HW:0]   row_err_r;

  logic [WW-1:0] in_col_nxt, out_col_nxt, wanted_col_nxt;
  logic [HW-1:0] in_row_nxt, out_row_nxt, wanted_row_nxt;
  logic [WW:0]   col_err_nxt;
  logic [HW:0]   row_err_nxt;
  logic [WW+1:0] col_sum;
  logic [HW+1:0] row_sum;
  logic          in_accept, row_hit, pix_hit, row_end, frame_end;
  logic          skid_valid_r, out_valid_r;

  assign in_tready = (state_r == ST_RUN) && !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    row_hit   = (in_row_r == wanted_row_r) && (out_row_r < nh_r);
    pix_hit   = row_hit && (in_col_r == wanted_col_r) && (out_col_r < nw_r);
    row_end   = out_col_r == (nw_r - WW'(1));
    frame_end = row_end && (out_row_r == (nh_r - HW'(1)));
    col_sum   = {1'b0, col_err_r} + {1'b0, col_step2_r};
    row_sum   = {1'b0, row_err_r} + {1'b0, row_step2_r};

    in_col_nxt     = in_col_r;
    in_row_nxt     = in_row_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    wanted_col_nxt = wanted_col_r;
    wanted_row_nxt = wanted_row_r;
    col_err_nxt    = col_err_r;
    row_err_nxt    = row_err_r;

    if (pix_hit) begin
      if (row_end) begin
        out_col_nxt    = '0;
        wanted_col_nxt = col_start_r;
        col_err_nxt    = col_err0_r;
      end else begin
        out_col_nxt = out_col_r + WW'(1);
        if (col_sum >= {1'b0, nw2_r}) begin
          col_err_nxt    = (WW+1)'(col_sum - {1'b0, nw2_r});
          wanted_col_nxt = wanted_col_r + cq_r + WW'(1);
        end else begin
          col_err_nxt    = col_sum[WW:0];
          wanted_col_nxt = wanted_col_r + cq_r;
        end
      end
    end

    if ((in_col_r + WW'(1)) >= fw_r) begin
      if ((in_row_r + HW'(1)) >= fh_r) begin
        // last source pixel: back to the start of a frame
        in_col_nxt     = '0;
        in_row_nxt     = '0;
        out_col_nxt    = '0;
        out_row_nxt    = '0;
        wanted_col_nxt = col_start_r;
        wanted_row_nxt = row_start_r;
        col_err_nxt    = col_err0_r;
        row_err_nxt    = row_err0_r;
      end else begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + HW'(1);
        if (row_hit) begin
          out_row_nxt    = out_row_r + HW'(1);
          out_col_nxt    = '0;
          wanted_col_nxt = col_start_r;
          col_err_nxt    = col_err0_r;
          if (row_sum >= {1'b0, nh2_r}) begin
            row_err_nxt    = (HW+1)'(row_sum - {1'b0, nh2_r});
            wanted_row_nxt = wanted_row_r + rq_r + HW'(1);
          end else begin
            row_err_nxt    = row_sum[HW:0];
            wanted_row_nxt = wanted_row_r + rq_r;
          end
        end
      end
    end else begin
      in_col_nxt = in_col_r + WW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_START) begin
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      wanted_col_r <= x0_r + (cq_r >> 1);
      wanted_row_r <= y0_r + (rq_r >> 1);
      col_err_r    <= (cq_r[0] ? {1'b0, nw_r} : '0) + {1'b0, cr_r};
      row_err_r    <= (rq_r[0] ? {1'b0, nh_r} : '0) + {1'b0, rr_r};
    end else if (in_accept) begin
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      wanted_col_r <= wanted_col_nxt;
      wanted_row_r <= wanted_row_nxt;
      col_err_r    <= col_err_nxt;
      row_err_r    <= row_err_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage
  // --------------------------------------------------------------------------
  logic [PIXEL_W-1:0] out_pixel_r, skid_pixel_r;
  logic               out_row_end_r, out_frame_end_r;
  logic               skid_row_end_r, skid_frame_end_r;
  logic               new_valid;

  assign new_valid = in_accept && pix_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= new_valid;
      end
    end else if (new_valid) begin
      // hold the new beat until the output register drains
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_pixel_r     <= skid_pixel_r;
        out_row_end_r   <= skid_row_end_r;
        out_frame_end_r <= skid_frame_end_r;
      end else begin
        out_pixel_r     <= in_tdata;
        out_row_end_r   <= row_end;
        out_frame_end_r <= frame_end;
      end
    end else if (new_valid) begin
      skid_pixel_r     <= in_tdata;
      skid_row_end_r   <= row_end;
      skid_frame_end_r <= frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tlast  = out_row_end_r;
  assign out_tuser  = out_frame_end_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid beat held without an output beat");

  a_out_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (out_col_r < nw_r))
    else $error("output column ran past the output width");

  a_in_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (in_col_r < fw_r))
    else $error("source column ran past the frame width");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end_r) |-> out_row_end_r)
    else $error("frame end beat without row end");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write |=> ((state_r == ST_GEOM) && !in_tready))
    else $error("register write did not restart the geometry setup");
`endif

endmodule
